// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define CRW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition in one cycle implies a condition in the next
`define CRW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	`CRW_ASSERT(label, clk, rst_n, (pre) |=> (post), msg)

`endif

// ----- design/crw_pkg.sv -----
`default_nettype none

package crw_pkg;

	localparam int ID_W    = 48;
	localparam int EXT_W   = 49;
	localparam int STAMP_W = 63;
	localparam int KIND_W  = 2;
	localparam int ERR_W   = 2;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_STEAL = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STEAL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERR   = 2'd2;

	localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_WINDOW = 2'd1;
	localparam logic [ERR_W-1:0] ERR_DUP    = 2'd2;
	localparam logic [ERR_W-1:0] ERR_BEYOND = 2'd3;

	typedef struct packed {
		logic              capture;
		logic              store;
		logic              err_load;
		logic [ERR_W-1:0]  err_code;
		logic              adv;
		logic              steal_start;
		logic              rd;
		logic              steal_step;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
		logic              emit_last;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic bend;
		logic in_win;
		logic dup;
		logic beyond;
		logic below;
		logic can_adv;
		logic last_steal;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ----- design/crw_ram.sv -----
`default_nettype none

module crw_ram #(
	parameter int WIDTH = 63,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- design/crw_ctrl.sv -----
`default_nettype none

module crw_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire crw_pkg::status_t st,
	output crw_pkg::cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_ERR   = 3'd2;
	localparam logic [2:0] ST_WALK  = 3'd3;
	localparam logic [2:0] ST_ACK   = 3'd4;
	localparam logic [2:0] ST_SREAD = 3'd5;
	localparam logic [2:0] ST_SOUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       add_batch;

	assign in_stall  = (state_q != ST_IDLE);
	assign add_batch = (st.op == crw_pkg::OP_ADD) && st.bend;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (st.op == crw_pkg::OP_ADD) begin
					if (!st.in_win) begin
						cmd.err_load = 1'b1;
						cmd.err_code = crw_pkg::ERR_WINDOW;
						state_d      = ST_ERR;
					end else if (st.dup) begin
						cmd.err_load = 1'b1;
						cmd.err_code = crw_pkg::ERR_DUP;
						state_d      = ST_ERR;
					end else begin
						cmd.store = 1'b1;
						state_d   = st.bend ? ST_WALK : ST_IDLE;
					end
				end else begin
					if (st.beyond) begin
						cmd.err_load = 1'b1;
						cmd.err_code = crw_pkg::ERR_BEYOND;
						state_d      = ST_ERR;
					end else if (st.below) begin
						state_d = ST_IDLE;
					end else begin
						cmd.steal_start = 1'b1;
						state_d         = ST_SREAD;
					end
				end
			end
			ST_ERR: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = crw_pkg::KIND_ERR;
					cmd.emit_last = !add_batch;
					state_d       = add_batch ? ST_WALK : ST_IDLE;
				end
			end
			ST_WALK: begin
				if (st.can_adv) begin
					cmd.adv = 1'b1;
				end else begin
					state_d = ST_ACK;
				end
			end
			ST_ACK: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = crw_pkg::KIND_ACK;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_SREAD: begin
				cmd.rd  = 1'b1;
				state_d = ST_SOUT;
			end
			ST_SOUT: begin
				if (st.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_kind  = crw_pkg::KIND_STEAL;
					cmd.emit_last  = st.last_steal;
					cmd.steal_step = 1'b1;
					state_d        = st.last_steal ? ST_IDLE : ST_SREAD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/crw_dp.sv -----
`default_nettype none

module crw_dp #(
	parameter int SLOTS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [crw_pkg::ID_W-1:0]          cfg_wr_data,
	input  wire logic                              op,
	input  wire logic [crw_pkg::ID_W-1:0]          ckpt_id,
	input  wire logic [crw_pkg::STAMP_W-1:0]       stamp,
	input  wire logic                              batch_end,
	input  wire logic                              out_stall,
	output logic                                   out_valid,
	output logic [crw_pkg::KIND_W-1:0]             kind,
	output logic signed [crw_pkg::EXT_W-1:0]       committed,
	output logic [crw_pkg::EXT_W-1:0]              id_limit,
	output logic                                   advanced,
	output logic [crw_pkg::STAMP_W-1:0]            stolen_stamp,
	output logic [crw_pkg::ERR_W-1:0]              error_code,
	output logic                                   last,
	input  wire crw_pkg::cmd_t                     cmd,
	output crw_pkg::status_t                       st
);

	localparam int SW = $clog2(SLOTS);
	localparam int GW = $clog2(SLOTS + 1);
	localparam int EW = crw_pkg::EXT_W;

	// captured request
	logic                          op_q;
	logic [crw_pkg::ID_W-1:0]      id_q;
	logic [crw_pkg::STAMP_W-1:0]   stamp_q;
	logic                          bend_q;
	logic [crw_pkg::ERR_W-1:0]     err_q;

	// window state
	logic [EW-1:0]                 ws_q;
	logic [EW-1:0]                 lim_q;
	logic [EW-1:0]                 commit_q;
	logic [EW-1:0]                 base_q;
	logic [SW-1:0]                 sslot_q;
	logic [SW-1:0]                 cslot_q;
	logic [GW-1:0]                 gap_q;
	logic [GW-1:0]                 cnt_q;
	logic [SLOTS-1:0]              filled_q;

	logic                          out_valid_q;
	logic [crw_pkg::STAMP_W-1:0]   rd_data;

	logic [EW:0]                   diff;
	logic                          below;
	logic                          in_win;
	logic [SW:0]                   slot_sum;
	logic [SW-1:0]                 slot_wr;
	logic [GW-1:0]                 steal_n;
	logic [SW-1:0]                 cslot_nxt;
	logic [SW-1:0]                 sslot_nxt;
	logic                          out_free;

	// offset of the request id from the window start
	assign diff     = {2'b00, id_q} - {1'b0, ws_q};
	assign below    = diff[EW];
	assign in_win   = !below && (diff[EW-1:0] < EW'(SLOTS));
	assign slot_sum = {1'b0, sslot_q} + {1'b0, diff[SW-1:0]};
	assign slot_wr  = (slot_sum >= (SW+1)'(SLOTS)) ? SW'(slot_sum - (SW+1)'(SLOTS))
		: slot_sum[SW-1:0];
	assign steal_n  = diff[GW-1:0] + GW'(1);

	assign cslot_nxt = (cslot_q == SW'(SLOTS - 1)) ? '0 : cslot_q + SW'(1);
	assign sslot_nxt = (sslot_q == SW'(SLOTS - 1)) ? '0 : sslot_q + SW'(1);
	assign out_free  = !out_valid_q || !out_stall;

	assign st.op         = op_q;
	assign st.bend       = bend_q;
	assign st.in_win     = in_win;
	assign st.dup        = filled_q[slot_wr];
	assign st.beyond     = $signed({2'b00, id_q}) > $signed({commit_q[EW-1], commit_q});
	assign st.below      = below;
	assign st.can_adv    = (gap_q < GW'(SLOTS)) && filled_q[cslot_q];
	assign st.last_steal = (cnt_q == GW'(1));
	assign st.out_free   = out_free;

	crw_ram #(
		.WIDTH(crw_pkg::STAMP_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.store),
		.wr_addr (slot_wr),
		.wr_data (stamp_q),
		.rd_en   (cmd.rd),
		.rd_addr (sslot_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			id_q    <= ckpt_id;
			stamp_q <= stamp;
			bend_q  <= batch_end;
		end
		if (cmd.err_load) begin
			err_q <= cmd.err_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q     <= '0;
			lim_q    <= EW'(SLOTS);
			commit_q <= '1;
			base_q   <= '1;
			sslot_q  <= '0;
			cslot_q  <= '0;
			gap_q    <= '0;
			cnt_q    <= '0;
			filled_q <= '0;
		end else if (cfg_wr_en) begin
			ws_q     <= {1'b0, cfg_wr_data};
			lim_q    <= {1'b0, cfg_wr_data} + EW'(SLOTS);
			commit_q <= {1'b0, cfg_wr_data} - EW'(1);
			base_q   <= {1'b0, cfg_wr_data} - EW'(1);
			sslot_q  <= '0;
			cslot_q  <= '0;
			gap_q    <= '0;
			cnt_q    <= '0;
			filled_q <= '0;
		end else begin
			if (cmd.store) begin
				filled_q[slot_wr] <= 1'b1;
			end
			if (cmd.adv) begin
				commit_q <= commit_q + EW'(1);
				cslot_q  <= cslot_nxt;
				gap_q    <= gap_q + GW'(1);
			end
			if (cmd.steal_start) begin
				ws_q  <= {1'b0, id_q} + EW'(1);
				lim_q <= {1'b0, id_q} + EW'(SLOTS + 1);
				gap_q <= gap_q - steal_n;
				cnt_q <= steal_n;
			end
			if (cmd.steal_step) begin
				filled_q[sslot_q] <= 1'b0;
				sslot_q           <= sslot_nxt;
				cnt_q             <= cnt_q - GW'(1);
			end
			if (cmd.emit && (cmd.emit_kind == crw_pkg::KIND_ACK)) begin
				base_q <= commit_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind         <= cmd.emit_kind;
			committed    <= commit_q;
			id_limit     <= lim_q;
			advanced     <= (cmd.emit_kind == crw_pkg::KIND_ACK) && (commit_q != base_q);
			stolen_stamp <= (cmd.emit_kind == crw_pkg::KIND_STEAL) ? rd_data : '0;
			error_code   <= (cmd.emit_kind == crw_pkg::KIND_ERR) ? err_q : crw_pkg::ERR_NONE;
			last         <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- design/checkpoint_reorder_window.sv -----
// Reorder window that commits checkpoints completing out of order.
// Input channel (in_valid / in_stall): one request per item; op selects
// an add of a timestamp for ckpt_id or a steal of all ids up to ckpt_id.
// Output channel (out_valid / out_stall): results, last marks the final
// result of a request; an add without batch_end and without error, and a
// steal below the window, give no result.
// Config: cfg_wr_en with cfg_wr_data sets the first id and restarts the
// window; write it only while no request is in flight.
// Timing: a request is taken and checked in the next cycle; an error
// result is loaded once the result register is free. A valid add is
// stored; with batch_end the commit point then advances one slot at a
// time over filled slots, ending with the acknowledge. A steal does a
// registered read of each slot's timestamp from the memory and loads it
// as a result before the next read. One request is handled at a time;
// in_stall stays high until its last result is loaded.
// Reset: all slots free, window starts at id 0, committed id is -1.
// A stalled receiver holds the result register and the next result load
// waits on it.
`default_nettype none

`include "assert_macros.svh"

module checkpoint_reorder_window #(
	parameter int SLOTS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [crw_pkg::ID_W-1:0]          cfg_wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              op,
	input  wire logic [crw_pkg::ID_W-1:0]          ckpt_id,
	input  wire logic [crw_pkg::STAMP_W-1:0]       stamp,
	input  wire logic                              batch_end,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [crw_pkg::KIND_W-1:0]             kind,
	output logic signed [crw_pkg::EXT_W-1:0]       committed,
	output logic [crw_pkg::EXT_W-1:0]              id_limit,
	output logic                                   advanced,
	output logic [crw_pkg::STAMP_W-1:0]            stolen_stamp,
	output logic [crw_pkg::ERR_W-1:0]              error_code,
	output logic                                   last
);

	crw_pkg::cmd_t    cmd;
	crw_pkg::status_t st;

	crw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	crw_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.op           (op),
		.ckpt_id      (ckpt_id),
		.stamp        (stamp),
		.batch_end    (batch_end),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.kind         (kind),
		.committed    (committed),
		.id_limit     (id_limit),
		.advanced     (advanced),
		.stolen_stamp (stolen_stamp),
		.error_code   (error_code),
		.last         (last),
		.cmd          (cmd),
		.st           (st)
	);

	`CRW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "request accepted but block not busy")
	`CRW_ASSERT(a_emit_into_free, clk, arst_n, cmd.emit |-> (!out_valid || !out_stall), "result loaded over a stalled result")
	`CRW_ASSERT(a_err_has_code, clk, arst_n, (out_valid && (kind == crw_pkg::KIND_ERR)) |-> (error_code != crw_pkg::ERR_NONE) && !advanced, "error result without code")

endmodule

`default_nettype wire

// ----- bench/checkpoint_reorder_window_check.sv -----
`timescale 1ns / 100ps

module checkpoint_reorder_window_check
	import crw_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [ID_W-1:0]           cfg_wr_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      op,
	input  logic [ID_W-1:0]           ckpt_id,
	input  logic [STAMP_W-1:0]        stamp,
	input  logic                      batch_end,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [KIND_W-1:0]         kind,
	input  logic signed [EXT_W-1:0]   committed,
	input  logic [EXT_W-1:0]          id_limit,
	input  logic                      advanced,
	input  logic [STAMP_W-1:0]        stolen_stamp,
	input  logic [ERR_W-1:0]          error_code,
	input  logic                      last,
	output int                        outstanding,
	output int                        results_seen,
	output int                        mismatches
);

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [EXT_W-1:0]   committed;
		logic [EXT_W-1:0]   id_limit;
		logic               advanced;
		logic [STAMP_W-1:0] stolen_stamp;
		logic [ERR_W-1:0]   error_code;
		logic               last;
	} outcome_t;

	outcome_t           pending_outcomes[$];
	logic [STAMP_W-1:0] ring_stamp[SLOTS];
	bit                 ring_full[SLOTS];
	longint             win_start;
	int                 ring_head;
	longint             commit_id;
	longint             batch_mark;

	function automatic int slot_for(longint id);
		return int'((longint'(ring_head) + id - win_start) % SLOTS);
	endfunction

	function automatic void restart_window(longint base);
		foreach (ring_full[i])
			ring_full[i] = 1'b0;
		win_start = base;
		ring_head = 0;
		commit_id = base - 1;
		batch_mark = commit_id;
	endfunction

	function automatic void push_outcome(logic [KIND_W-1:0] k, logic adv,
			logic [STAMP_W-1:0] st, logic [ERR_W-1:0] err);
		outcome_t o;
		o.kind = k;
		o.committed = EXT_W'(commit_id);
		o.id_limit = EXT_W'(win_start + SLOTS);
		o.advanced = adv;
		o.stolen_stamp = st;
		o.error_code = err;
		o.last = 1'b0;
		pending_outcomes.push_back(o);
	endfunction

	function automatic void forecast_request(logic op_in, logic [ID_W-1:0] id_in,
			logic [STAMP_W-1:0] st, logic bend);
		longint id;
		int s;
		int before_n;
		outcome_t tail;
		logic [STAMP_W-1:0] taken[$];
		id = longint'(id_in);
		before_n = pending_outcomes.size();
		if (op_in == OP_ADD) begin
			if (id < win_start || id >= win_start + SLOTS) begin
				push_outcome(KIND_ERR, 1'b0, '0, ERR_WINDOW);
			end else begin
				s = slot_for(id);
				if (ring_full[s]) begin
					push_outcome(KIND_ERR, 1'b0, '0, ERR_DUP);
				end else begin
					ring_full[s] = 1'b1;
					ring_stamp[s] = st;
				end
			end
			if (bend) begin
				while (commit_id + 1 < win_start + SLOTS && ring_full[slot_for(commit_id + 1)])
					commit_id++;
				push_outcome(KIND_ACK, commit_id != batch_mark, '0, ERR_NONE);
				batch_mark = commit_id;
			end
		end else if (id > commit_id) begin
			push_outcome(KIND_ERR, 1'b0, '0, ERR_BEYOND);
		end else if (id >= win_start) begin
			for (longint i = win_start; i <= id; i++) begin
				s = slot_for(i);
				taken.push_back(ring_stamp[s]);
				ring_full[s] = 1'b0;
			end
			ring_head = slot_for(id + 1);
			win_start = id + 1;
			foreach (taken[i])
				push_outcome(KIND_STEAL, 1'b0, taken[i], ERR_NONE);
		end
		if (pending_outcomes.size() > before_n) begin
			tail = pending_outcomes.pop_back();
			tail.last = 1'b1;
			pending_outcomes.push_back(tail);
		end
	endfunction

	function automatic void compare_field(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_result();
		outcome_t want;
		results_seen++;
		if (pending_outcomes.size() == 0) begin
			$error("unexpected result: kind %0d error_code %0d stolen_stamp %0d",
				kind, error_code, stolen_stamp);
			mismatches++;
			return;
		end
		want = pending_outcomes.pop_front();
		compare_field("kind", want.kind, kind);
		compare_field("committed", $signed(want.committed), committed);
		compare_field("id_limit", want.id_limit, id_limit);
		compare_field("advanced", want.advanced, advanced);
		compare_field("stolen_stamp", want.stolen_stamp, stolen_stamp);
		compare_field("error_code", want.error_code, error_code);
		compare_field("last", want.last, last);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_outcomes.delete();
			restart_window(0);
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_wr_en)
				restart_window(longint'(cfg_wr_data));
			if (in_valid && !in_stall)
				forecast_request(op, ckpt_id, stamp, batch_end);
			outstanding <= pending_outcomes.size();
		end
	end

endmodule

// ----- bench/checkpoint_reorder_window_test.sv -----
`timescale 1ns / 100ps

module checkpoint_reorder_window_test;
	import crw_pkg::*;

	localparam int     SLOTS       = 64;
	localparam longint MAX_ID      = (longint'(1) << ID_W) - 1;
	localparam int     CYCLE_LIMIT = 1000000;
	localparam int     LONG_HOLD   = 300;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [ID_W-1:0]         cfg_wr_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    op = OP_ADD;
	logic [ID_W-1:0]         ckpt_id = '0;
	logic [STAMP_W-1:0]      stamp = '0;
	logic                    batch_end = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [KIND_W-1:0]       kind;
	logic signed [EXT_W-1:0] committed;
	logic [EXT_W-1:0]        id_limit;
	logic                    advanced;
	logic [STAMP_W-1:0]      stolen_stamp;
	logic [ERR_W-1:0]        error_code;
	logic                    last;

	int outstanding;
	int results_seen;
	int mismatches;
	int cycle_count = 0;
	int requests_sent = 0;
	int settings_used = 0;
	logic long_hold_req = 1'b0;
	bit long_hold_done = 1'b0;

	// sender's own view of the window, used to shape requests
	longint gen_win = 0;
	longint gen_commit = -1;
	bit     gen_filled[SLOTS];

	checkpoint_reorder_window #(.SLOTS(SLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.ckpt_id(ckpt_id),
		.stamp(stamp),
		.batch_end(batch_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.committed(committed),
		.id_limit(id_limit),
		.advanced(advanced),
		.stolen_stamp(stolen_stamp),
		.error_code(error_code),
		.last(last)
	);

	checkpoint_reorder_window_check #(.SLOTS(SLOTS)) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.ckpt_id(ckpt_id),
		.stamp(stamp),
		.batch_end(batch_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.committed(committed),
		.id_limit(id_limit),
		.advanced(advanced),
		.stolen_stamp(stolen_stamp),
		.error_code(error_code),
		.last(last),
		.outstanding(outstanding),
		.results_seen(results_seen),
		.mismatches(mismatches)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: changing stall patterns plus one long hold-off
	initial begin : receiver
		int mode_left;
		int mode;
		int tick;
		mode_left = 0;
		mode = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 150);
				end
				mode_left--;
				tick++;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (tick % 5 < 2);
				endcase
			end
		end
	end

	function automatic logic [STAMP_W-1:0] any_stamp();
		return STAMP_W'({$urandom, $urandom});
	endfunction

	function automatic longint any_id();
		return longint'({$urandom, $urandom}) & MAX_ID;
	endfunction

	function automatic void gen_restart(longint base);
		foreach (gen_filled[i])
			gen_filled[i] = 1'b0;
		gen_win = base;
		gen_commit = base - 1;
	endfunction

	function automatic int gen_fill_count();
		int n;
		n = 0;
		foreach (gen_filled[i])
			n += gen_filled[i];
		return n;
	endfunction

	function automatic void gen_track(logic op_in, longint id, logic bend);
		if (op_in == OP_ADD) begin
			if (id >= gen_win && id < gen_win + SLOTS)
				gen_filled[id % SLOTS] = 1'b1;
			if (bend)
				while (gen_commit + 1 < gen_win + SLOTS && gen_filled[(gen_commit + 1) % SLOTS])
					gen_commit++;
		end else if (id <= gen_commit && id >= gen_win) begin
			for (longint i = gen_win; i <= id; i++)
				gen_filled[i % SLOTS] = 1'b0;
			gen_win = id + 1;
		end
	endfunction

	task automatic send_request(logic op_in, longint id, logic [STAMP_W-1:0] st, logic bend);
		gen_track(op_in, id, bend);
		in_valid <= 1'b1;
		op <= op_in;
		ckpt_id <= ID_W'(id);
		stamp <= st;
		batch_end <= bend;
		requests_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_first_id(longint base);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ID_W'(base);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gen_restart(base);
		settings_used++;
	endtask

	task automatic noise_request();
		longint id;
		longint top;
		top = (gen_win + SLOTS - 1 < MAX_ID) ? gen_win + SLOTS - 1 : MAX_ID;
		case ($urandom_range(0, 5))
			0: send_request(OP_ADD, any_id(), any_stamp(), 1'($urandom_range(0, 1)));
			1: send_request(OP_ADD, (gen_win > 0) ? gen_win - 1 : gen_win + SLOTS,
				any_stamp(), 1'($urandom_range(0, 1)));
			2: begin
				id = any_id();
				for (longint c = gen_win; c <= top; c++)
					if (gen_filled[c % SLOTS])
						id = c;
				send_request(OP_ADD, id, any_stamp(), 1'($urandom_range(0, 1)));
			end
			3: begin
				id = gen_commit + 1 + $urandom_range(0, 3);
				if (id > MAX_ID)
					id = any_id();
				send_request(OP_STEAL, id, any_stamp(), 1'($urandom_range(0, 1)));
			end
			4: begin
				id = gen_win - 1 - $urandom_range(0, 3);
				if (id < 0)
					id = 0;
				send_request(OP_STEAL, id, any_stamp(), 1'($urandom_range(0, 1)));
			end
			default: send_request(OP_STEAL, any_id(), any_stamp(), 1'($urandom_range(0, 1)));
		endcase
	endtask

	task automatic random_request(int steal_pct);
		longint top;
		longint c;
		int pick;
		int start_off;
		bit found;
		pick = $urandom_range(0, 99);
		top = (gen_win + SLOTS - 1 < MAX_ID) ? gen_win + SLOTS - 1 : MAX_ID;
		found = 1'b0;
		c = gen_win;
		if (pick < 10 || top < gen_win) begin
			noise_request();
		end else if (gen_commit >= gen_win &&
				(pick < 10 + steal_pct || (steal_pct > 0 && gen_fill_count() > 44))) begin
			send_request(OP_STEAL, gen_win + $urandom_range(0, int'(gen_commit - gen_win)),
				any_stamp(), 1'($urandom_range(0, 1)));
		end else begin
			start_off = $urandom_range(0, 7);
			for (int n = 0; n < SLOTS && !found; n++) begin
				c = gen_win + (start_off + n) % SLOTS;
				found = (c <= top) && !gen_filled[c % SLOTS];
			end
			if (found)
				send_request(OP_ADD, c, any_stamp(), $urandom_range(0, 3) == 0);
			else if (gen_commit >= gen_win)
				send_request(OP_STEAL, gen_commit, any_stamp(), 1'($urandom_range(0, 1)));
			else
				send_request(OP_ADD, gen_win, any_stamp(), 1'b1);
		end
	endtask

	initial begin : stimulus
		longint first_ids[4];
		int steal_rates[4];
		int burst_left;
		first_ids[0] = 0;
		first_ids[1] = any_id();
		first_ids[2] = MAX_ID - 3 * SLOTS;
		first_ids[3] = 37;
		steal_rates[0] = 0;
		steal_rates[1] = 15;
		steal_rates[2] = 20;
		steal_rates[3] = 12;
		burst_left = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window at the reset id
		send_request(OP_STEAL, 0, any_stamp(), 1'b0);
		send_request(OP_ADD, SLOTS, '1, 1'b1);
		send_request(OP_ADD, 1, '1, 1'b1);
		send_request(OP_ADD, 0, '0, 1'b0);
		send_request(OP_ADD, 0, any_stamp(), 1'b1);
		send_request(OP_ADD, SLOTS - 1, any_stamp(), 1'b0);
		send_request(OP_ADD, 2, any_stamp(), 1'b1);
		send_request(OP_STEAL, 3, any_stamp(), 1'b0);
		send_request(OP_STEAL, 1, any_stamp(), 1'b1);
		send_request(OP_STEAL, 1, any_stamp(), 1'b0);
		send_request(OP_STEAL, 0, any_stamp(), 1'b0);
		send_request(OP_ADD, 1, any_stamp(), 1'b0);
		send_request(OP_ADD, SLOTS + 1, any_stamp(), 1'b0);
		send_request(OP_ADD, SLOTS + 2, any_stamp(), 1'b1);

		// top of the id space
		write_first_id(MAX_ID);
		send_request(OP_STEAL, MAX_ID, any_stamp(), 1'b0);
		send_request(OP_ADD, MAX_ID, '1, 1'b1);
		send_request(OP_ADD, MAX_ID - 1, any_stamp(), 1'b0);
		send_request(OP_STEAL, MAX_ID, any_stamp(), 1'b0);
		send_request(OP_ADD, MAX_ID, any_stamp(), 1'b1);
		send_request(OP_STEAL, MAX_ID, any_stamp(), 1'b0);
		send_request(OP_STEAL, 0, any_stamp(), 1'b0);

		foreach (first_ids[p]) begin
			write_first_id(first_ids[p]);
			burst_left = 0;
			if (p == 1)
				long_hold_req <= 1'b1;
			for (int k = 0; k < 90; k++) begin
				if (p == 2 && k == 45) begin
					wait_drained();
					burst_left = 0;
				end
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 15)) @(posedge clk);
				end
				burst_left--;
				random_request(steal_rates[p]);
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("run covered %0d requests over %0d first-id settings, %0d results checked",
			requests_sent, settings_used, results_seen);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
